// ----- hw/rtl/vm_pkg.sv -----
package vm_pkg;

  localparam int unsigned COMP_BITS = 32;
  localparam int unsigned MAG_BITS  = 31;
  localparam int unsigned Q_BITS    = 5;
  localparam int unsigned Q_MAX     = 30;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] comp_x;
    logic signed [COMP_BITS-1:0] comp_y;
  } in_word_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                saturated;
  } out_word_t;

endpackage

// ----- hw/rtl/vm_isqrt.sv -----
// Pipelined digit-by-digit integer square root, one result bit per stage.
module vm_isqrt
  import vm_pkg::*;
#(
  parameter int unsigned DW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_i,
  input  logic [2*DW-1:0] rad_i,
  output logic            vld_o,
  output logic [DW-1:0]   root_o
);

  logic [DW:0]     rem_r  [DW-1];
  logic [2*DW-1:0] rad_r  [DW-1];
  logic [DW-1:0]   root_r [DW];
  logic            vld_r  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW:0]     rem_in;
    logic [DW-1:0]   root_in;
    logic [2*DW-1:0] rad_in;
    logic            vld_in;
    logic [DW+2:0]   rem_sh;
    logic [DW+3:0]   diff;
    logic            take;
    logic [DW:0]     rem_nxt;
    logic [DW-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    // bring down the next radicand digit pair, trial subtract 4*root+1
    assign rem_sh   = {rem_in, rad_in[2*DW-1 -: 2]};
    assign diff     = {1'b0, rem_sh} - {2'b00, root_in, 2'b01};
    assign take     = ~diff[DW+3];
    assign rem_nxt  = take ? diff[DW:0] : rem_sh[DW:0];
    assign root_nxt = {root_in[DW-2:0], take};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      root_r[k] <= root_nxt;
    end

    if (k < DW-1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        rad_r[k] <= {rad_in[2*DW-3:0], 2'b00};
      end
    end
  end

  assign vld_o  = vld_r[DW-1];
  assign root_o = root_r[DW-1];

endmodule

// ----- hw/rtl/vector_magnitude.sv -----
// vector_magnitude: floor(sqrt(x*x + y*y)) of two signed fixed-point components,
// saturated to the largest positive DATA_WIDTH-bit value.
//
//   channel  ports                      handshake
//   input    start, busy, in_word       taken when start && !busy
//   result   out_valid, out_word        one-cycle strobe, cannot be held off
//   config   cfg_we, cfg_wdata          q_format written when cfg_we
//
// Stages: abs, square, add, DATA_WIDTH root stages (one result bit each), output
// register. A word can be taken every cycle.
// busy is always low; the pipeline never stalls since the receiver cannot.
// Reset (rst_n low, synchronous) clears the valid bits and q_format.
// The Q format cancels out of the root, so q_format is held but not used.
module vector_magnitude
  import vm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_word_t          in_word,
  output logic              out_valid,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [Q_BITS-1:0] cfg_wdata
);

  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned LAT = DW + 4;

  logic              take;
  logic [Q_BITS-1:0] q_format_r;

  // stage 1: magnitudes of the low DW bits of each component
  logic [DW-1:0]   xs, ys, ax_nxt, ay_nxt, ax_r, ay_r;
  logic            vld1_r;
  // stage 2: exact squares
  logic [2*DW-1:0] sqx_nxt, sqy_nxt, sqx_r, sqy_r;
  logic            vld2_r;
  // stage 3: sum, at most 2^(2*DW-1) so it fits
  logic [2*DW-1:0] sum_r;
  logic            vld3_r;
  // root pipeline and output
  logic            root_vld;
  logic [DW-1:0]   root;
  logic            sat;
  logic [DW-2:0]   mag_clip;
  logic            out_valid_r;
  out_word_t       out_word_r;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_format_r <= '0;
    end else if (cfg_we) begin
      q_format_r <= cfg_wdata;
    end
  end

  assign xs     = in_word.comp_x[DW-1:0];
  assign ys     = in_word.comp_y[DW-1:0];
  // two's complement negate; most negative maps to 2^(DW-1) unsigned
  assign ax_nxt = xs[DW-1] ? (~xs + 1'b1) : xs;
  assign ay_nxt = ys[DW-1] ? (~ys + 1'b1) : ys;
  assign sqx_nxt = ax_r * ax_r;
  assign sqy_nxt = ay_r * ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld1_r      <= take;
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      out_valid_r <= root_vld;
    end
  end

  always_ff @(posedge clk) begin
    ax_r  <= ax_nxt;
    ay_r  <= ay_nxt;
    sqx_r <= sqx_nxt;
    sqy_r <= sqy_nxt;
    sum_r <= sqx_r + sqy_r;
  end

  vm_isqrt #(
    .DW (DW)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld3_r),
    .rad_i  (sum_r),
    .vld_o  (root_vld),
    .root_o (root)
  );

  // root above 2^(DW-1)-1 clips to that limit
  assign sat      = root[DW-1];
  assign mag_clip = sat ? {(DW-1){1'b1}} : root[DW-2:0];

  always_ff @(posedge clk) begin
    out_word_r.magnitude <= MAG_BITS'(mag_clip);
    out_word_r.saturated <= sat;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // every accepted word comes out as a result on out_valid
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##LAT out_valid)
    else $error("accepted word produced no result");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, LAT))
    else $error("result without an accepted word");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.saturated) |->
      (out_word.magnitude == MAG_BITS'({(DW-1){1'b1}})))
    else $error("saturated result not at the limit");

  a_cfg_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (q_format_r == $past(cfg_wdata)))
    else $error("q_format write lost");

endmodule
